/* sv/b64d_pkg.sv */
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam int unsigned CMDQ_DEPTH = 4;

	// one decoded group handed from the front to the back
	typedef struct packed {
		logic [23:0] word;    // bytes left aligned, oldest in [23:16]
		logic [1:0]  nbytes;  // 1..3 bytes to emit
		logic        last;
		logic        bad;
	} b64d_cmd_t;

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [5:0] v;
		v = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			v = 6'd62;
		end else if (c == 8'h2F) begin
			v = 6'd63;
		end
		return v;
	endfunction

endpackage

/* sv/b64d_front.sv */
module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          char_code,
	input  logic                final_char,
	input  logic                push,
	input  logic                q_full,
	output logic                cmd_wr,
	output b64d_pkg::b64d_cmd_t cmd
);
	import b64d_pkg::*;

	logic [17:0] buf_q;
	logic [1:0]  pos_q;
	logic [1:0]  pad_q;

	logic        accept;
	logic        is_pad;
	logic [5:0]  v;
	logic [23:0] word;
	logic [23:0] aligned;
	logic [2:0]  t;
	logic [2:0]  lim;
	logic [2:0]  cut;
	logic [1:0]  count;

	assign accept = push && !q_full;
	assign is_pad = (char_code == PAD_CHAR);
	assign v      = sextet_of(char_code);
	assign word   = {buf_q, v};

	// trailing pads in the final group, capped at n-2 where n = pos+1
	assign t     = is_pad ? ({1'b0, pad_q} + 3'd1) : 3'd0;
	assign lim   = {1'b0, pos_q} - 3'd1;
	assign cut   = (t < lim) ? t : lim;
	assign count = 2'({1'b0, pos_q} - cut);

	always_comb begin
		case (pos_q)
			2'd3:    aligned = word;
			2'd2:    aligned = {word[17:0], 6'd0};
			2'd1:    aligned = {word[11:0], 12'd0};
			default: aligned = 24'd0;
		endcase
	end

	always_comb begin
		if (!final_char) begin
			cmd.word   = word;
			cmd.nbytes = 2'd3;
			cmd.last   = 1'b0;
			cmd.bad    = 1'b0;
		end else if (pos_q == 2'd0) begin
			// lone tail character
			cmd.word   = 24'd0;
			cmd.nbytes = 2'd1;
			cmd.last   = 1'b1;
			cmd.bad    = 1'b1;
		end else begin
			cmd.word   = aligned;
			cmd.nbytes = count;
			cmd.last   = 1'b1;
			cmd.bad    = 1'b0;
		end
	end

	assign cmd_wr = accept && (final_char || pos_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			pos_q <= '0;
			pad_q <= '0;
		end else if (accept) begin
			if (cmd_wr) begin
				buf_q <= '0;
				pos_q <= '0;
				pad_q <= '0;
			end else begin
				buf_q <= word[17:0];
				pos_q <= pos_q + 2'd1;
				if (is_pad) begin
					pad_q <= (pad_q == 2'd3) ? 2'd3 : pad_q + 2'd1;
				end else begin
					pad_q <= 2'd0;
				end
			end
		end
	end

endmodule

/* sv/b64d_cmdq.sv */
module b64d_cmdq #(
	parameter int unsigned DEPTH = b64d_pkg::CMDQ_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  b64d_pkg::b64d_cmd_t wr_cmd,
	input  logic                rd,
	output b64d_pkg::b64d_cmd_t rd_cmd,
	output logic                full,
	output logic                empty
);
	import b64d_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	b64d_cmd_t         mem [DEPTH];
	logic [AW-1:0]     wptr_q;
	logic [AW-1:0]     rptr_q;
	logic [CW-1:0]     cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_cmd = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* sv/b64d_back.sv */
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64d_pkg::b64d_cmd_t cmd,
	input  logic                q_empty,
	output logic                q_rd,
	input  logic                pop,
	output logic                empty,
	output logic [7:0]          data_byte,
	output logic                last_byte,
	output logic                bad_tail
);
	import b64d_pkg::*;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       bad_q;
	logic [1:0] idx_q;

	logic       load;
	logic       final_of_cmd;
	logic [7:0] sel_byte;

	// output register refills whenever a command is waiting and the register is free or being taken this cycle
	assign load         = !q_empty && (!out_valid_q || pop);
	assign final_of_cmd = (idx_q + 2'd1) == cmd.nbytes;
	assign q_rd         = load && final_of_cmd;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = cmd.word[23:16];
			2'd1:    sel_byte = cmd.word[15:8];
			default: sel_byte = cmd.word[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_of_cmd ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			last_q <= cmd.last && final_of_cmd;
			bad_q  <= cmd.bad;
		end
	end

	assign empty     = !out_valid_q;
	assign data_byte = byte_q;
	assign last_byte = last_q;
	assign bad_tail  = bad_q;

endmodule

/* sv/base64_stream_decoder_core.sv */
// Flow: a character that closes a group is written into the command queue, and its first byte
// shows on the outputs once the byte emitter has loaded it into its output register.
// Throughput: one character per cycle in while the queue has room, one byte per cycle
// out while popped; a full group of four characters makes three bytes, so output keeps up.
// A small command queue between the decoder and the byte emitter absorbs bursts.
// Reset (arst_n low) clears group state, queue pointers and the output valid flag.
module base64_stream_decoder_core #(
	parameter int unsigned CMDQ_DEPTH = b64d_pkg::CMDQ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_code,
	input  logic       final_char,
	input  logic       push,
	output logic       full,
	output logic [7:0] data_byte,
	output logic       last_byte,
	output logic       bad_tail,
	output logic       empty,
	input  logic       pop
);
	import b64d_pkg::*;

	b64d_cmd_t wr_cmd;
	b64d_cmd_t rd_cmd;
	logic      cmd_wr;
	logic      q_rd;
	logic      q_empty;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_code  (char_code),
		.final_char (final_char),
		.push       (push),
		.q_full     (full),
		.cmd_wr     (cmd_wr),
		.cmd        (wr_cmd)
	);

	b64d_cmdq #(
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wr_cmd (wr_cmd),
		.rd     (q_rd),
		.rd_cmd (rd_cmd),
		.full   (full),
		.empty  (q_empty)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rd_cmd),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.bad_tail  (bad_tail)
	);

endmodule

/* sv/b64d_checker.sv */
module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic [7:0] data_byte,
	input logic       last_byte,
	input logic       bad_tail,
	input logic       empty,
	input logic       pop
);

	// error result always closes the text
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && bad_tail |-> last_byte)
		else $error("bad_tail without last_byte");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && bad_tail |-> data_byte == 8'd0)
		else $error("bad_tail with nonzero data_byte");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before pop");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(data_byte) && $stable(last_byte) && $stable(bad_tail))
		else $error("result changed before pop");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (.*);
